>>> design/cfp_pkg.sv
`timescale 1ns / 1ps

package cfp_pkg;

   localparam int unsigned FRAME_BYTES = 20;
   localparam int unsigned COUNT_W     = 5;

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type LAST_IDX  = COUNT_W'(FRAME_BYTES - 1);
   localparam count_type CRC_BYTES = COUNT_W'(18);
   localparam count_type VER_IDX   = COUNT_W'(2);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_VERSION = 2'd1,
      ST_CRC     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_VERSION     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic step;
      logic clear;
   } crc_ctl_type;

endpackage

>>> design/cfp_crc.sv
`timescale 1ns / 1ps

module cfp_crc import cfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [7:0]  data,
   output logic [15:0] crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] nxt;

   // byte-wide reflected update, one bit per step
   always_comb begin
      nxt = (ctl.start ? CRC_INIT : crc_ff) ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         nxt = nxt[0] ? ((nxt >> 1) ^ CRC_POLY) : (nxt >> 1);
      end
      crc_in = crc_ff;
      priority if (ctl.clear) begin
         crc_in = CRC_INIT;
      end else if (ctl.start || ctl.step) begin
         crc_in = nxt;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

>>> design/crc16_frame_parser.sv
`timescale 1ns / 1ps

// Serial frame receiver: takes one received byte per beat on req_ and hunts for the
// sync pair set in registers 0 and 1, then collects a 20-byte frame with no resync,
// checking the version byte (register 2) and a CRC-16/MODBUS over bytes 0..17 against
// the little-endian CRC in bytes 18..19. One status beat leaves on rsp_ per frame, the
// cycle after its last byte is taken; payload fields are zero unless status is ok.
// A byte is taken every cycle; the CRC step and capture finish in the cycle the byte
// arrives. Only a frame's last byte waits, and only while an earlier status beat is
// still held on rsp_. Write registers only with no frame in flight; not enforced.

module crc16_frame_parser import cfp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_frame_status,
   output logic [7:0]         rsp_command,
   output logic [7:0]         rsp_sequence_res,
   output logic [7:0]         rsp_flag_bits,
   output logic signed [15:0] rsp_joint_a,
   output logic signed [15:0] rsp_joint_b,
   output logic signed [15:0] rsp_joint_c,
   output logic signed [15:0] rsp_joint_d,
   output logic signed [15:0] rsp_joint_e,
   output logic signed [15:0] rsp_joint_f
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'b001,
      PH_SYNC2 = 3'b010,
      PH_BODY  = 3'b100
   } phase_type;

   logic [7:0]  sync_first_ff, sync_second_ff, version_ff;
   phase_type   phase_ff, phase_in;
   count_type   count_ff, count_in;
   logic [7:0]  store_ff [VER_IDX:LAST_IDX-1];
   logic [15:0] crc;
   crc_ctl_type crc_ctl;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  command_ff, sequence_ff, flags_ff;
   logic [15:0] joint_ff [6];
   logic [15:0] joint_in [6];

   logic        accept;
   logic        last_byte;
   logic        done;
   logic [7:0]  b;

   assign b         = req_rx_byte;
   assign last_byte = (phase_ff == PH_BODY) && (count_ff == LAST_IDX);
   assign req_ready = !(last_byte && rsp_valid_ff && !rsp_ready);
   assign accept    = req_valid && req_ready;
   assign done      = accept && last_byte;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'hAA;
         sync_second_ff <= 8'h55;
         version_ff     <= 8'h01;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            CSR_VERSION:     version_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sync hunt and frame counting
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      crc_ctl  = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               priority if (b == sync_second_ff) begin
                  phase_in     = PH_BODY;
                  count_in     = COUNT_W'(2);
                  crc_ctl.step = 1'b1;
               end else if (b == sync_first_ff) begin
                  phase_in      = PH_SYNC2;
                  count_in      = COUNT_W'(1);
                  crc_ctl.start = 1'b1;
               end else begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end
            end
            PH_BODY: begin
               crc_ctl.step = (count_ff < CRC_BYTES);
               if (count_ff == LAST_IDX) begin
                  phase_in      = PH_HUNT;
                  count_in      = '0;
                  crc_ctl.clear = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            default: begin
               if (b == sync_first_ff) begin
                  phase_in      = PH_SYNC2;
                  count_in      = COUNT_W'(1);
                  crc_ctl.start = 1'b1;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   cfp_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .data  (b),
      .crc   (crc)
   );

   // frame bytes 2..18; byte 19 is taken straight from the last beat
   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_BODY && count_ff < LAST_IDX) begin
         store_ff[count_ff] <= b;
      end
   end

   // result
   always_comb begin
      priority if (store_ff[VER_IDX] != version_ff) begin
         status_in = ST_VERSION;
      end else if ({b, store_ff[LAST_IDX-1]} != crc) begin
         status_in = ST_CRC;
      end else begin
         status_in = ST_OK;
      end
      for (int j = 0; j < 6; j++) begin
         joint_in[j] = (status_in == ST_OK) ? {store_ff[7 + 2*j], store_ff[6 + 2*j]} : 16'h0000;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         status_ff   <= status_in;
         command_ff  <= (status_in == ST_OK) ? store_ff[3] : 8'h00;
         sequence_ff <= (status_in == ST_OK) ? store_ff[4] : 8'h00;
         flags_ff    <= (status_in == ST_OK) ? store_ff[5] : 8'h00;
         joint_ff    <= joint_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_command      = command_ff;
   assign rsp_sequence_res = sequence_ff;
   assign rsp_flag_bits    = flags_ff;
   assign rsp_joint_a      = joint_ff[0];
   assign rsp_joint_b      = joint_ff[1];
   assign rsp_joint_c      = joint_ff[2];
   assign rsp_joint_d      = joint_ff[3];
   assign rsp_joint_e      = joint_ff[4];
   assign rsp_joint_f      = joint_ff[5];

endmodule

>>> design/cfp_checker.sv
`timescale 1ns / 1ps

module cfp_checker import cfp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_frame_status,
   input logic [7:0]         rsp_command,
   input logic [7:0]         rsp_sequence_res,
   input logic [7:0]         rsp_flag_bits,
   input logic signed [15:0] rsp_joint_a,
   input logic signed [15:0] rsp_joint_b,
   input logic signed [15:0] rsp_joint_c,
   input logic signed [15:0] rsp_joint_d,
   input logic signed [15:0] rsp_joint_e,
   input logic signed [15:0] rsp_joint_f
);

   // stalled status beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_command) && $stable(rsp_joint_a))
      else $error("status beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_status == ST_OK || rsp_frame_status == ST_VERSION
         || rsp_frame_status == ST_CRC))
      else $error("bad frame status code");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != ST_OK |-> rsp_command == 8'h00
         && rsp_sequence_res == 8'h00 && rsp_flag_bits == 8'h00
         && rsp_joint_a == 16'sd0 && rsp_joint_b == 16'sd0 && rsp_joint_c == 16'sd0
         && rsp_joint_d == 16'sd0 && rsp_joint_e == 16'sd0 && rsp_joint_f == 16'sd0)
      else $error("payload not cleared on bad frame");

   // input only stalls behind a held status beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a status beat needs a full frame, so two in a row need a fresh last byte
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid || $past(req_valid && req_ready))
      else $error("status beat without a frame");

endmodule

bind crc16_frame_parser cfp_checker u_cfp_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cfp_pkg::*;

   localparam int STALL_LIMIT = 1000;

   typedef enum logic [1:0] {
      HUNT_FIRST  = 2'd0,
      HUNT_SECOND = 2'd1,
      IN_BODY     = 2'd2
   } hunt_state_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       command;
      logic [7:0]       sequence_res;
      logic [7:0]       flag_bits;
      logic [5:0][15:0] joints;
   } frame_result_type;

   // leads[0] goes out first, then leads[1]
   typedef struct packed {
      logic [1:0][7:0] leads;
      logic [1:0]      lead_n;
      logic [7:0]      ver;
      logic [7:0]      body;
      logic            crc_bad;
      logic            typed;
      status_type      typed_status;
   } frame_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = CSR_SYNC_FIRST;
   logic [7:0]         csr_wdata = 8'h00;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_frame_status;
   logic [7:0]         rsp_command;
   logic [7:0]         rsp_sequence_res;
   logic [7:0]         rsp_flag_bits;
   logic signed [15:0] rsp_joint_a;
   logic signed [15:0] rsp_joint_b;
   logic signed [15:0] rsp_joint_c;
   logic signed [15:0] rsp_joint_d;
   logic signed [15:0] rsp_joint_e;
   logic signed [15:0] rsp_joint_f;

   logic [7:0]    cfg_sync_first  = 8'hAA;
   logic [7:0]    cfg_sync_second = 8'h55;
   logic [7:0]    cfg_version     = 8'h01;

   hunt_state_type rx_state = HUNT_FIRST;
   logic [4:0]    rx_count = '0;
   logic [15:0]   rx_crc   = CRC_INIT;
   logic [7:0]    rx_frame [FRAME_BYTES];

   frame_result_type pending_frames [$];
   logic [7:0]    tx_frame [FRAME_BYTES];
   logic          quiet_run = 1'b0;
   int            mismatches = 0;
   int            idle_cycles = 0;
   int            bytes_sent = 0;
   int            frames_predicted = 0;

   frame_row_type dir_rows [13] = '{
      '{16'h0000, 2'd0, 8'h01, 8'h00, 1'b0, 1'b1, ST_OK},
      '{16'h0000, 2'd0, 8'h01, 8'hFF, 1'b0, 1'b0, ST_OK},
      '{16'h0000, 2'd0, 8'h01, 8'h80, 1'b0, 1'b0, ST_OK},
      '{16'h0000, 2'd0, 8'h01, 8'h7F, 1'b0, 1'b0, ST_OK},
      '{16'h0000, 2'd0, 8'h01, 8'hAA, 1'b0, 1'b0, ST_OK},
      '{16'h0000, 2'd0, 8'h01, 8'h55, 1'b0, 1'b0, ST_OK},
      '{16'h0000, 2'd0, 8'h02, 8'h11, 1'b0, 1'b1, ST_VERSION},
      '{16'h0000, 2'd0, 8'hFF, 8'h22, 1'b0, 1'b1, ST_VERSION},
      '{16'h0000, 2'd0, 8'h01, 8'h33, 1'b1, 1'b1, ST_CRC},
      '{16'h0000, 2'd0, 8'h00, 8'h44, 1'b1, 1'b1, ST_VERSION},
      '{{8'h00, 8'hAA}, 2'd1, 8'h01, 8'h5A, 1'b0, 1'b0, ST_OK},
      '{{8'h13, 8'hAA}, 2'd2, 8'h01, 8'h66, 1'b0, 1'b0, ST_OK},
      '{{8'h00, 8'h55}, 2'd2, 8'h01, 8'h77, 1'b0, 1'b0, ST_OK}
   };

   crc16_frame_parser dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_command      (rsp_command),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_flag_bits    (rsp_flag_bits),
      .rsp_joint_a      (rsp_joint_a),
      .rsp_joint_b      (rsp_joint_b),
      .rsp_joint_c      (rsp_joint_c),
      .rsp_joint_d      (rsp_joint_d),
      .rsp_joint_e      (rsp_joint_e),
      .rsp_joint_f      (rsp_joint_f)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                     input logic [7:0] b);
      crc ^= {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

   function automatic void begin_frame(input logic [7:0] b);
      rx_frame[0] = b;
      rx_count    = 5'd1;
      rx_state    = HUNT_SECOND;
      rx_crc      = crc16_modbus_step(CRC_INIT, b);
   endfunction

   function automatic void track_byte(input logic [7:0] b);
      frame_result_type res;
      logic [15:0]   got_crc;
      case (rx_state)
         IN_BODY: begin
            rx_frame[rx_count] = b;
            if (rx_count < CRC_BYTES) rx_crc = crc16_modbus_step(rx_crc, b);
            rx_count++;
            if (rx_count == FRAME_BYTES) begin
               res = '0;
               got_crc = {rx_frame[19], rx_frame[18]};
               if (rx_frame[VER_IDX] != cfg_version) begin
                  res.status = ST_VERSION;
               end else if (got_crc != rx_crc) begin
                  res.status = ST_CRC;
               end else begin
                  res.status       = ST_OK;
                  res.command      = rx_frame[3];
                  res.sequence_res = rx_frame[4];
                  res.flag_bits    = rx_frame[5];
                  for (int j = 0; j < 6; j++) begin
                     res.joints[j] = {rx_frame[7 + 2 * j], rx_frame[6 + 2 * j]};
                  end
               end
               pending_frames.push_back(res);
               frames_predicted++;
               rx_state = HUNT_FIRST;
               rx_count = '0;
               rx_crc   = CRC_INIT;
            end
         end
         HUNT_SECOND: begin
            if (b == cfg_sync_second) begin
               rx_frame[1] = b;
               rx_count    = 5'd2;
               rx_state    = IN_BODY;
               rx_crc      = crc16_modbus_step(rx_crc, b);
            end else if (b == cfg_sync_first) begin
               begin_frame(b);
            end else begin
               rx_state = HUNT_FIRST;
               rx_count = '0;
            end
         end
         default: begin
            if (b == cfg_sync_first) begin_frame(b);
            else rx_state = HUNT_FIRST;
         end
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (!quiet_run && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      track_byte(b);
      bytes_sent++;
   endtask

   // bytes 2..17 come from the caller
   task automatic send_frame(input logic crc_bad);
      logic [15:0] crc;
      crc = CRC_INIT;
      tx_frame[0] = cfg_sync_first;
      tx_frame[1] = cfg_sync_second;
      for (int i = 0; i < CRC_BYTES; i++) crc = crc16_modbus_step(crc, tx_frame[i]);
      if (crc_bad) crc ^= 16'(1 << $urandom_range(15));
      tx_frame[18] = crc[7:0];
      tx_frame[19] = crc[15:8];
      for (int i = 0; i < FRAME_BYTES; i++) send_byte(tx_frame[i]);
   endtask

   // back to hunting, then hold off until every status beat is in
   task automatic settle();
      logic [7:0] filler;
      filler = 8'h00;
      while (filler == cfg_sync_first || filler == cfg_sync_second) filler++;
      while (rx_state != HUNT_FIRST) send_byte(filler);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] first_sync, input logic [7:0] second_sync,
                                input logic [7:0] version);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_wdata <= first_sync;
      @(posedge clock);
      csr_index <= CSR_SYNC_SECOND;
      csr_wdata <= second_sync;
      @(posedge clock);
      csr_index <= CSR_VERSION;
      csr_wdata <= version;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_sync_first  = first_sync;
      cfg_sync_second = second_sync;
      cfg_version     = version;
   endtask

   task automatic run_random(input int byte_goal, input int frame_goal);
      int start_bytes;
      int start_frames;
      int roll;
      start_bytes  = bytes_sent;
      start_frames = frames_predicted;
      while (bytes_sent - start_bytes < byte_goal ||
             frames_predicted - start_frames < frame_goal) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            tx_frame[2] = ($urandom_range(99) < 12) ? 8'($urandom_range(255)) : cfg_version;
            for (int i = 3; i < 18; i++) tx_frame[i] = 8'($urandom_range(255));
            send_frame($urandom_range(99) < 12);
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
         end else begin
            // broken sync pair
            send_byte(cfg_sync_first);
            if ($urandom_range(1)) send_byte(cfg_sync_first);
            send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_ready   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         rsp_ready <= quiet_run || ($urandom_range(99) >= 17);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (pending_frames.size() == 0) begin
               $error("status beat with no frame pending");
               mismatches++;
            end else begin
               want = pending_frames.pop_front();
               check_field("rsp_frame_status", want.status, rsp_frame_status);
               check_field("rsp_command", want.command, rsp_command);
               check_field("rsp_sequence_res", want.sequence_res, rsp_sequence_res);
               check_field("rsp_flag_bits", want.flag_bits, rsp_flag_bits);
               check_field("rsp_joint_a", want.joints[0], rsp_joint_a);
               check_field("rsp_joint_b", want.joints[1], rsp_joint_b);
               check_field("rsp_joint_c", want.joints[2], rsp_joint_c);
               check_field("rsp_joint_d", want.joints[3], rsp_joint_d);
               check_field("rsp_joint_e", want.joints[4], rsp_joint_e);
               check_field("rsp_joint_f", want.joints[5], rsp_joint_f);
            end
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("crc16_frame_parser regression: fail");
      $finish;
   end

   initial begin
      frame_row_type    row;
      frame_result_type typed_res;
      int               frames_before;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         for (int k = 0; k < row.lead_n; k++) send_byte(row.leads[k]);
         tx_frame[2] = row.ver;
         for (int i = 3; i < 18; i++) tx_frame[i] = row.body;
         frames_before = frames_predicted;
         send_frame(row.crc_bad);
         if (row.typed) begin
            typed_res = '0;
            typed_res.status = row.typed_status;
            if (frames_predicted != frames_before) void'(pending_frames.pop_back());
            pending_frames.push_back(typed_res);
         end
      end

      settle();
      load_settings(8'h00, 8'hFF, 8'hFF);
      run_random(45, 2);

      settle();
      quiet_run <= 1'b1;
      load_settings(8'hFF, 8'h00, 8'h00);
      run_random(90, 3);

      settle();
      quiet_run <= 1'b0;
      load_settings(8'h5A, 8'h5A, 8'h33);
      run_random(45, 2);

      settle();
      load_settings(8'($urandom), 8'($urandom), 8'($urandom));
      run_random(45, 2);

      settle();
      load_settings(8'hAA, 8'h55, 8'h01);
      run_random(45, 2);

      settle();
      if (mismatches == 0) $display("crc16_frame_parser regression: pass");
      else $display("crc16_frame_parser regression: fail");
      $finish;
   end

endmodule

>>> files.f
design/cfp_pkg.sv
design/cfp_crc.sv
design/crc16_frame_parser.sv
design/cfp_checker.sv
tb/tb_top.sv
